// ===== src/bse_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bse_pkg
// Shared constants and controller/datapath interface types of the sort engine.
// ----------------------------------------------------------------------------
package bse_pkg;

	localparam int MAX_ELEMENTS_DEF = 64;
	localparam int DATA_WIDTH_DEF   = 32;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic store;      // input transfer: write value or drop it
		logic store_last; // input transfer carries the last mark
		logic pass_init;  // take element 0 as carry, start reading element 1
		logic step;       // compare carry with next element, write back the lower one
		logic pass_end;   // write carry to the top of the pass, shrink the range
		logic out_rd;     // read the next sorted element
		logic out_cap;    // load the output register
		logic out_adv;    // advance the output index
		logic finish;     // clear count and drop flag for the next array
	} bse_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic k_end;    // compare index reached the top of the pass
		logic m_zero;   // single stored element, nothing to sort
		logic m_one;    // this pass is the final one
		logic swapped;  // the current pass exchanged at least one pair
		logic out_last; // the output register holds the final element
	} bse_status_t;

endpackage : bse_pkg
`default_nettype wire

// ===== src/bse_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule : bse_ram
`default_nettype wire

// ===== src/bse_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bse_ctrl
// Sequencer for load, bubble passes and ordered readout.
// ----------------------------------------------------------------------------
module bse_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic                 in_last,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output bse_pkg::bse_cmd_t         cmd,
	input  wire bse_pkg::bse_status_t status
);

	import bse_pkg::*;

	typedef enum logic [2:0] {
		S_LOAD,
		S_P0,
		S_P1,
		S_RUN,
		S_PEND,
		S_ORD,
		S_OCAP,
		S_OWAIT
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready  = (state_q == S_LOAD);
	assign out_valid = (state_q == S_OWAIT);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_LOAD: begin
				cmd.store      = in_valid;
				cmd.store_last = in_valid && in_last;
				if (in_valid && in_last) begin
					state_d = S_P0;
				end
			end
			S_P0: begin
				// single element: skip straight to readout
				state_d = status.m_zero ? S_ORD : S_P1;
			end
			S_P1: begin
				cmd.pass_init = 1'b1;
				state_d       = S_RUN;
			end
			S_RUN: begin
				cmd.step = 1'b1;
				if (status.k_end) begin
					state_d = S_PEND;
				end
			end
			S_PEND: begin
				cmd.pass_end = 1'b1;
				// stop early once a pass leaves everything in place
				state_d = (status.m_one || !status.swapped) ? S_ORD : S_P0;
			end
			S_ORD: begin
				cmd.out_rd = 1'b1;
				state_d    = S_OCAP;
			end
			S_OCAP: begin
				cmd.out_cap = 1'b1;
				state_d     = S_OWAIT;
			end
			S_OWAIT: begin
				if (out_ready) begin
					if (status.out_last) begin
						cmd.finish = 1'b1;
						state_d    = S_LOAD;
					end else begin
						cmd.out_adv = 1'b1;
						state_d     = S_ORD;
					end
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule : bse_ctrl
`default_nettype wire

// ===== src/bse_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bse_dp
// Element buffer, counters, carry register and compare-exchange unit.
// ----------------------------------------------------------------------------
module bse_dp #(
	parameter int MAX_ELEMENTS = bse_pkg::MAX_ELEMENTS_DEF,
	parameter int DATA_WIDTH   = bse_pkg::DATA_WIDTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bse_pkg::bse_cmd_t cmd,
	output bse_pkg::bse_status_t   status,
	input  wire logic [DATA_WIDTH-1:0] value,
	output logic      [DATA_WIDTH-1:0] sorted_value,
	output logic                       last_out,
	output logic                       overflow
);

	import bse_pkg::*;

	localparam int AW = $clog2(MAX_ELEMENTS);
	localparam int CW = $clog2(MAX_ELEMENTS + 1);

	logic [CW-1:0]         count_q;
	logic                  dropped_q;
	logic [AW-1:0]         k_q;
	logic [AW-1:0]         m_q;
	logic [AW-1:0]         ocnt_q;
	logic                  swapped_q;
	logic [DATA_WIDTH-1:0] carry_q;
	logic [DATA_WIDTH-1:0] out_data_q;
	logic                  out_last_q;
	logic                  out_ovf_q;

	logic                  count_full;
	logic                  swap;
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [DATA_WIDTH-1:0] ram_wdata;
	logic [AW-1:0]         ram_raddr;
	logic [DATA_WIDTH-1:0] ram_rdata;

	assign count_full = (count_q == CW'(MAX_ELEMENTS));
	assign swap       = $signed(carry_q) > $signed(ram_rdata);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = carry_q;
		if (cmd.store) begin
			ram_we    = !count_full;
			ram_waddr = count_q[AW-1:0];
			ram_wdata = value;
		end else if (cmd.step) begin
			// lower of the pair settles one slot below the compare index
			ram_we    = 1'b1;
			ram_waddr = k_q - AW'(1);
			ram_wdata = swap ? ram_rdata : carry_q;
		end else if (cmd.pass_end) begin
			ram_we    = 1'b1;
			ram_waddr = m_q;
			ram_wdata = carry_q;
		end
	end

	always_comb begin
		ram_raddr = '0;
		if (cmd.pass_init) begin
			ram_raddr = AW'(1);
		end else if (cmd.step) begin
			ram_raddr = k_q + AW'(1);
		end else if (cmd.out_rd) begin
			ram_raddr = ocnt_q;
		end
	end

	bse_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (MAX_ELEMENTS)
	) u_buf (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
			k_q       <= '0;
			m_q       <= '0;
			ocnt_q    <= '0;
			swapped_q <= 1'b0;
		end else begin
			if (cmd.store) begin
				if (count_full) begin
					dropped_q <= 1'b1;
				end else begin
					count_q <= count_q + CW'(1);
				end
			end
			if (cmd.store_last) begin
				m_q <= count_full ? AW'(MAX_ELEMENTS - 1) : count_q[AW-1:0];
			end
			if (cmd.pass_init) begin
				k_q       <= AW'(1);
				swapped_q <= 1'b0;
			end
			if (cmd.step) begin
				k_q <= k_q + AW'(1);
				if (swap) begin
					swapped_q <= 1'b1;
				end
			end
			if (cmd.pass_end) begin
				m_q <= m_q - AW'(1);
			end
			if (cmd.out_adv) begin
				ocnt_q <= ocnt_q + AW'(1);
			end
			if (cmd.finish) begin
				count_q   <= '0;
				dropped_q <= 1'b0;
				ocnt_q    <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pass_init) begin
			carry_q <= ram_rdata;
		end else if (cmd.step && !swap) begin
			carry_q <= ram_rdata;
		end
		if (cmd.out_cap) begin
			out_data_q <= ram_rdata;
			out_last_q <= (CW'(ocnt_q) + CW'(1)) == count_q;
			out_ovf_q  <= dropped_q;
		end
	end

	assign status.k_end    = (k_q == m_q);
	assign status.m_zero   = (m_q == '0);
	assign status.m_one    = (m_q == AW'(1));
	assign status.swapped  = swapped_q;
	assign status.out_last = out_last_q;

	assign sorted_value = out_data_q;
	assign last_out     = out_last_q;
	assign overflow     = out_ovf_q;

endmodule : bse_dp
`default_nettype wire

// ===== src/bubble_sort_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bubble_sort_engine
// Buffers a frame of signed values and returns it sorted in ascending order.
// ----------------------------------------------------------------------------
// Usage:
// - Slave channel: one signed value per transfer on s_tdata, s_tlast on the
//   final value of a frame. Values beyond MAX_ELEMENTS are dropped.
// - Master channel: the stored values in ascending order (equal values keep
//   their arrival order), m_tlast on the final one, m_tuser set on every
//   result of a frame that lost values.
// - Load stores each value as its transfer is accepted; s_tready is high only while loading.
// - Sorting runs bubble passes through the buffer RAM (one write and one read
//   port): the range shrinks by one per pass, and sorting stops after the
//   first pass without an exchange, so an already sorted frame costs one pass.
//   The pace of a pass is set by the RAM, one read and one write per cycle.
// - Readout handles each result in order: address, registered read, present;
//   a low m_tready simply holds the current result, nothing is lost.
// - After the final result is taken the block returns to loading.
// - Reset (arst_n low) drops any partial frame and returns to loading; the
//   buffer contents are not cleared, only entries of the current frame are read.
// ----------------------------------------------------------------------------
module bubble_sort_engine #(
	parameter int MAX_ELEMENTS = bse_pkg::MAX_ELEMENTS_DEF,
	parameter int DATA_WIDTH   = bse_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// slave channel
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [((DATA_WIDTH + 7) / 8)*8-1:0] s_tdata,  // value, zero pad
	input  wire logic                                s_tlast,  // last_in
	// master channel
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic      [((DATA_WIDTH + 7) / 8)*8-1:0] m_tdata,  // sorted_value, zero pad
	output logic                                     m_tlast,  // last_out
	output logic                                     m_tuser   // overflow
);

	import bse_pkg::*;

	localparam int TDW = ((DATA_WIDTH + 7) / 8) * 8;

	bse_cmd_t              cmd;
	bse_status_t           status;
	logic [DATA_WIDTH-1:0] sorted_value;

	// Sequencer: handshakes and step commands
	bse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_last   (s_tlast),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.status    (status)
	);

	// Buffer, compare-exchange and output register
	bse_dp #(
		.MAX_ELEMENTS (MAX_ELEMENTS),
		.DATA_WIDTH   (DATA_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.value        (s_tdata[DATA_WIDTH-1:0]),
		.sorted_value (sorted_value),
		.last_out     (m_tlast),
		.overflow     (m_tuser)
	);

	// zero-fill the byte padding above the value
	assign m_tdata = TDW'(sorted_value);

endmodule : bubble_sort_engine
`default_nettype wire
